// ===== src/u8t_pkg.sv =====
package u8t_pkg;

    // Configuration register indexes, decoded from paddr[2].
    localparam logic REG_BIT_PERIOD  = 1'b0;
    localparam logic REG_HALF_PERIOD = 1'b1;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned RX_CNT_W   = PERIOD_W + 1;
    localparam int unsigned BYTE_W     = 8;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST  = 16'd416;
    localparam logic [PERIOD_W-1:0] HALF_PERIOD_RST = 16'd208;

    // Line and status flags of the transmitter after one tick.
    typedef struct packed {
        logic line;
        logic busy;
        logic done;
    } tx_status_t;

    // Status and data of the receiver after one tick.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              busy;
    } rx_status_t;

endpackage

// ===== src/u8t_tx.sv =====
module u8t_tx #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [u8t_pkg::PERIOD_W-1:0]  period,
    input  logic                          start,
    input  logic [u8t_pkg::BYTE_W-1:0]    data_in,
    output u8t_pkg::tx_status_t           status
);

    localparam int unsigned FRAME_BITS = DATA_BITS + 2;
    localparam int unsigned LEFT_W     = $clog2(FRAME_BITS + 1);

    logic [FRAME_BITS-1:0]          shift_reg, shift_next;
    logic [LEFT_W-1:0]              left_reg, left_next;
    logic                           active_reg, active_next;
    logic [u8t_pkg::PERIOD_W-1:0]   count_reg, count_next;
    logic                           level_reg, level_next;
    logic                           done;
    logic [u8t_pkg::PERIOD_W:0]     count_inc;
    logic [15:0]                    byte_ext;
    logic [DATA_BITS-1:0]           data_bits;

    assign byte_ext  = {8'h00, data_in};
    assign data_bits = byte_ext[DATA_BITS-1:0];
    assign count_inc = {1'b0, count_reg} + 17'd1;

    always_comb begin
        shift_next  = shift_reg;
        left_next   = left_reg;
        active_next = active_reg;
        count_next  = count_reg;
        level_next  = level_reg;
        done        = 1'b0;
        if (active_reg) begin
            if (count_inc >= {1'b0, period}) begin
                count_next = '0;
                if (left_reg != '0) begin
                    level_next = shift_reg[0];
                    shift_next = shift_reg >> 1;
                    left_next  = left_reg - LEFT_W'(1);
                end else begin
                    level_next  = 1'b1;
                    active_next = 1'b0;
                    done        = 1'b1;
                end
            end else begin
                count_next = count_inc[u8t_pkg::PERIOD_W-1:0];
            end
        end else if (start) begin
            // Stop bit, data LSB first, start bit in the low position.
            shift_next  = {1'b1, data_bits, 1'b0};
            left_next   = LEFT_W'(FRAME_BITS);
            count_next  = '0;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            left_reg   <= '0;
            active_reg <= 1'b0;
            count_reg  <= '0;
            level_reg  <= 1'b1;
        end else if (adv) begin
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            level_reg  <= level_next;
        end
    end

    assign status.line = level_next;
    assign status.busy = active_next;
    assign status.done = done;

endmodule

// ===== src/u8t_rx.sv =====
module u8t_rx #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [u8t_pkg::PERIOD_W-1:0]  period,
    input  logic [u8t_pkg::PERIOD_W-1:0]  half_period,
    input  logic                          line,
    output u8t_pkg::rx_status_t           status
);

    localparam int unsigned IDX_W = $clog2(DATA_BITS + 1);

    logic [DATA_BITS-1:0]           shift_reg, shift_next;
    logic [IDX_W-1:0]               index_reg, index_next;
    logic                           active_reg, active_next;
    logic [u8t_pkg::RX_CNT_W-1:0]   count_reg, count_next;
    logic                           prev_reg;
    logic [u8t_pkg::BYTE_W-1:0]     held_reg, held_next;
    logic                           valid;
    logic [u8t_pkg::RX_CNT_W-1:0]   count_inc;
    logic [u8t_pkg::RX_CNT_W-1:0]   target;
    logic [15:0]                    shift_ext;

    assign count_inc = count_reg + u8t_pkg::RX_CNT_W'(1);
    // The first sample waits an extra half period to land mid-bit.
    assign target    = (index_reg == '0)
                     ? ({1'b0, period} + {1'b0, half_period})
                     : {1'b0, period};
    assign shift_ext = 16'(shift_reg);

    always_comb begin
        shift_next  = shift_reg;
        index_next  = index_reg;
        active_next = active_reg;
        count_next  = count_reg;
        held_next   = held_reg;
        valid       = 1'b0;
        if (active_reg) begin
            if (count_inc >= target) begin
                count_next = '0;
                if (index_reg < IDX_W'(DATA_BITS)) begin
                    shift_next = {line, shift_reg[DATA_BITS-1:1]};
                    index_next = index_reg + IDX_W'(1);
                end else begin
                    held_next   = shift_ext[u8t_pkg::BYTE_W-1:0];
                    valid       = 1'b1;
                    active_next = 1'b0;
                    index_next  = '0;
                end
            end else begin
                count_next = count_inc;
            end
        end else if (prev_reg && !line) begin
            active_next = 1'b1;
            count_next  = '0;
            index_next  = '0;
            shift_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            index_reg  <= '0;
            active_reg <= 1'b0;
            count_reg  <= '0;
            prev_reg   <= 1'b1;
            held_reg   <= '0;
        end else if (adv) begin
            shift_reg  <= shift_next;
            index_reg  <= index_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            prev_reg   <= line;
            held_reg   <= held_next;
        end
    end

    assign status.valid = valid;
    assign status.data  = held_next;
    assign status.busy  = active_next;

endmodule

// ===== src/uart_8n1_transceiver_top.sv =====
// Channel   | Handshake             | Carries
// ----------+-----------------------+------------------------------------------
// input     | s_valid / s_ready     | one timer tick: s_rx_line, s_tx_start, s_tx_byte
// result    | m_valid / m_ready     | m_tx_line, m_tx_busy, m_tx_done, m_rx_valid,
//           |                       | m_rx_byte, m_rx_busy for that tick
// config    | psel/penable/pwrite   | bit_period at 0x0, half_period at 0x4
//
// On each accepted tick request the transmitter and receiver state advance at the
// edge that accepts it, and the result is captured in the output register at that
// same edge, so one request per cycle is sustained while m_ready stays high.
// Reset is synchronous on aresetn low and clears the control state; both
// configuration registers return to their documented defaults.
// s_ready is high whenever the output register is empty or is being emptied in
// the same cycle, so a stall on the result side holds the input side for as
// long as the previous result waits.
module uart_8n1_transceiver_top #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_rx_line,
    input  logic                            s_tx_start,
    input  logic [7:0]                      s_tx_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_tx_line,
    output logic                            m_tx_busy,
    output logic                            m_tx_done,
    output logic                            m_rx_valid,
    output logic [7:0]                      m_rx_byte,
    output logic                            m_rx_busy,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8t_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [u8t_pkg::PERIOD_W-1:0] bit_period_reg;
    logic [u8t_pkg::PERIOD_W-1:0] half_period_reg;
    logic [u8t_pkg::PERIOD_W-1:0] period_eff;
    logic                         cfg_write;
    logic                         accept;
    logic                         m_valid_reg;
    u8t_pkg::tx_status_t          tx_status;
    u8t_pkg::rx_status_t          rx_status;
    u8t_pkg::tx_status_t          tx_out_reg;
    u8t_pkg::rx_status_t          rx_out_reg;

    // Configuration port: writes complete in the access phase, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg  <= u8t_pkg::BIT_PERIOD_RST;
            half_period_reg <= u8t_pkg::HALF_PERIOD_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                u8t_pkg::REG_BIT_PERIOD:  bit_period_reg  <= pwdata[u8t_pkg::PERIOD_W-1:0];
                u8t_pkg::REG_HALF_PERIOD: half_period_reg <= pwdata[u8t_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            u8t_pkg::REG_BIT_PERIOD:  prdata = 32'(bit_period_reg);
            u8t_pkg::REG_HALF_PERIOD: prdata = 32'(half_period_reg);
            default:                  prdata = '0;
        endcase
    end

    // A programmed period of zero behaves as one tick per bit.
    assign period_eff = (bit_period_reg == '0) ? u8t_pkg::PERIOD_W'(1) : bit_period_reg;

    // A tick is taken whenever the output register can receive its result.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    u8t_tx #(
        .DATA_BITS (DATA_BITS)
    ) u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (accept),
        .period  (period_eff),
        .start   (s_tx_start),
        .data_in (s_tx_byte),
        .status  (tx_status)
    );

    u8t_rx #(
        .DATA_BITS (DATA_BITS)
    ) u_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (accept),
        .period      (period_eff),
        .half_period (half_period_reg),
        .line        (s_rx_line),
        .status      (rx_status)
    );

    // Output register: valid flag is reset, the payload follows each request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tx_out_reg <= tx_status;
            rx_out_reg <= rx_status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_tx_line  = tx_out_reg.line;
    assign m_tx_busy  = tx_out_reg.busy;
    assign m_tx_done  = tx_out_reg.done;
    assign m_rx_valid = rx_out_reg.valid;
    assign m_rx_byte  = rx_out_reg.data;
    assign m_rx_busy  = rx_out_reg.busy;

endmodule

// ===== src/u8t_checker.sv =====
module u8t_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_tx_line,
    input  logic                            m_tx_busy,
    input  logic                            m_tx_done,
    input  logic                            m_rx_valid,
    input  logic                            m_rx_busy
);

    // A result that is not taken stays presented.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // With the output register empty the block must take a tick.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // A finished frame leaves the line idle and the transmitter free.
    a_tx_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_done |-> m_tx_line && !m_tx_busy)
        else $error("transmit done with line low or still busy");

    // A presented byte closes the receive frame.
    a_rx_valid_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_valid |-> !m_rx_busy)
        else $error("receive byte presented while still busy");

    // A tick taken produces a result at the next edge.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted tick produced no result");

endmodule

bind uart_8n1_transceiver_top u8t_checker u_checker (.*);
